FILE: design/rste_pkg.sv
`default_nettype none
package rste_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int WORD_BITS   = 32;
    localparam int TABLES      = 4;
    localparam int TAB_BITS    = $clog2(TABLES);
    localparam int IDX_BITS    = $clog2(MAX_ENTRIES);
    localparam int ADDR_BITS   = TAB_BITS + IDX_BITS;
    localparam int DEPTH       = TABLES * MAX_ENTRIES;
    localparam int CNT_BITS    = 7;
    localparam int BIT_BITS    = 5;
    localparam int CMD_BITS    = 3;
    localparam int APB_AW      = 5;
    localparam int APB_DW      = 32;
    localparam int REG_BITS    = 3;

    localparam int IN_RAW_BITS  = BIT_BITS + 4 * WORD_BITS + IDX_BITS;
    localparam int IN_DATA_BITS = ((IN_RAW_BITS + 7) / 8) * 8;
    localparam int IN_PAD_BITS  = IN_DATA_BITS - IN_RAW_BITS;
    localparam int IN_USER_BITS = CMD_BITS + TAB_BITS;
    localparam int OUT_DATA_BITS = 3 * WORD_BITS;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_SET_BIT   = 3'd0,
        CMD_CLEAR_BIT = 3'd1,
        CMD_MASKED    = 3'd2,
        CMD_WRITE     = 3'd3,
        CMD_RECALC    = 3'd4
    } cmd_t;

    typedef enum logic [TAB_BITS-1:0] {
        TAB_PREPARE = 2'd0,
        TAB_MAIN    = 2'd1,
        TAB_STATIC  = 2'd2,
        TAB_DYNAMIC = 2'd3
    } tab_t;

    typedef enum logic [REG_BITS-1:0] {
        REG_PREPARE_COUNT = 3'd0,
        REG_MAIN_COUNT    = 3'd1,
        REG_STATIC_COUNT  = 3'd2,
        REG_DYNAMIC_COUNT = 3'd3,
        REG_CONST_SENS    = 3'd4
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FLUSH,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [IN_PAD_BITS-1:0] pad;
        logic [WORD_BITS-1:0]   entry_effect;
        logic [WORD_BITS-1:0]   entry_condition;
        logic [IDX_BITS-1:0]    entry_index;
        logic [WORD_BITS-1:0]   keep_bits;
        logic [WORD_BITS-1:0]   on_bits;
        logic [BIT_BITS-1:0]    bit_index;
    } in_data_t;

    typedef struct packed {
        logic [TAB_BITS-1:0] table_select;
        logic [CMD_BITS-1:0] command;
    } in_user_t;

    typedef struct packed {
        logic [WORD_BITS-1:0] status_value;
        logic [WORD_BITS-1:0] sensitive_result;
        logic [WORD_BITS-1:0] main_result;
    } out_data_t;

    typedef struct packed {
        logic [WORD_BITS-1:0] condition;
        logic [WORD_BITS-1:0] effect;
    } entry_t;

    function automatic logic [CNT_BITS-1:0] clip_count(input logic [CNT_BITS-1:0] cnt);
        logic [CNT_BITS-1:0] lim;
        lim = CNT_BITS'(MAX_ENTRIES);
        return (cnt > lim) ? lim : cnt;
    endfunction

endpackage
`default_nettype wire

FILE: design/relay_scheme_term_evaluator_unit.sv
// Set bit, clear bit, masked update and entry write are handled in the idle state; one item a cycle while idle.
// Recalculate walks the four tables from the entry memory, one entry read per cycle:
// the walk reads n entries, n the sum of the clipped counts (at most 256), then passes the flush and emit states.
// The next item is taken once the result is loaded into the output register.
// Reset (aresetn low, synchronous) clears status, counts, constant mask and all entry
// valid bits; an entry never written reads as zero, so the memory needs no clearing pass.
`default_nettype none
module relay_scheme_term_evaluator_unit
    import rste_pkg::*;
(
    input  wire                      aclk,
    input  wire                      aresetn,
    input  wire                      s_tvalid,
    output logic                     s_tready,
    // bit_index, on_bits, keep_bits, entry_index, entry_condition, entry_effect, zero pad
    input  wire  [IN_DATA_BITS-1:0]  s_tdata,
    // command, table_select
    input  wire  [IN_USER_BITS-1:0]  s_tuser,
    output logic                     m_tvalid,
    input  wire                      m_tready,
    // main_result, sensitive_result, status_value
    output logic [OUT_DATA_BITS-1:0] m_tdata,
    input  wire                      psel,
    input  wire                      penable,
    input  wire                      pwrite,
    input  wire  [APB_AW-1:0]        paddr,
    input  wire  [APB_DW-1:0]        pwdata,
    output logic [APB_DW-1:0]        prdata,
    output logic                     pready
);

    logic [CNT_BITS-1:0]  cnt_reg [TABLES];
    logic [WORD_BITS-1:0] const_sens_reg;

    state_t               state_reg, state_next;
    logic [WORD_BITS-1:0] status_reg, status_next;
    logic [TAB_BITS-1:0]  tab_reg, tab_next;
    logic [CNT_BITS-1:0]  idx_reg, idx_next;
    logic [WORD_BITS-1:0] prep_acc_reg, prep_acc_next;
    logic [WORD_BITS-1:0] main_acc_reg, main_acc_next;
    logic [WORD_BITS-1:0] sens_acc_reg, sens_acc_next;
    logic                 out_valid_reg, out_valid_next;
    out_data_t            out_data_reg, out_data_next;

    entry_t               mem [DEPTH];
    logic [DEPTH-1:0]     vld_reg;
    entry_t               rd_data_reg;
    logic                 rd_vld_reg;
    logic                 rd_pend_reg;
    logic [TAB_BITS-1:0]  rd_tab_reg;

    logic                 mem_we;
    logic [ADDR_BITS-1:0] mem_waddr;
    logic                 rd_en;
    logic [ADDR_BITS-1:0] rd_addr;

    in_data_t             in_d;
    in_user_t             in_u;
    logic                 in_acc;
    logic [WORD_BITS-1:0] bit_mask;
    logic [CNT_BITS-1:0]  cur_cnt;
    logic [CNT_BITS-1:0]  wr_cnt;
    logic [WORD_BITS-1:0] view;
    logic [WORD_BITS-1:0] judge;
    logic                 hit;
    logic                 cfg_we;
    logic [REG_BITS-1:0]  cfg_idx;

    assign in_d     = in_data_t'(s_tdata);
    assign in_u     = in_user_t'(s_tuser);
    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign bit_mask = WORD_BITS'(1) << in_d.bit_index;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign pready   = 1'b1;
    assign cfg_we   = psel && penable && pwrite;
    assign cfg_idx  = paddr[APB_AW-1:2];

    assign cur_cnt   = clip_count(cnt_reg[tab_reg]);
    assign wr_cnt    = clip_count(cnt_reg[in_u.table_select]);
    assign mem_waddr = {in_u.table_select, in_d.entry_index};
    assign rd_addr   = {tab_reg, idx_reg[IDX_BITS-1:0]};

    assign view  = status_reg | prep_acc_reg;
    assign judge = (rd_tab_reg == TAB_PREPARE) ? status_reg : view;
    assign hit   = rd_pend_reg && rd_vld_reg
                   && ((rd_data_reg.condition & ~judge) == '0);

    always_comb begin
        state_next     = state_reg;
        status_next    = status_reg;
        tab_next       = tab_reg;
        idx_next       = idx_reg;
        prep_acc_next  = prep_acc_reg;
        main_acc_next  = main_acc_reg;
        sens_acc_next  = sens_acc_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        mem_we         = 1'b0;
        rd_en          = 1'b0;

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        if (hit) begin
            unique case (tab_t'(rd_tab_reg))
                TAB_PREPARE: prep_acc_next = prep_acc_reg | rd_data_reg.effect;
                TAB_MAIN:    main_acc_next = main_acc_reg | rd_data_reg.effect;
                TAB_STATIC,
                TAB_DYNAMIC: sens_acc_next = sens_acc_reg | rd_data_reg.effect;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    unique case (in_u.command)
                        CMD_SET_BIT:   status_next = status_reg | bit_mask;
                        CMD_CLEAR_BIT: status_next = status_reg & ~bit_mask;
                        CMD_MASKED:    status_next = (status_reg & in_d.keep_bits)
                                                     | in_d.on_bits;
                        CMD_WRITE:     mem_we = ({1'b0, in_d.entry_index} < wr_cnt);
                        CMD_RECALC: begin
                            tab_next      = TAB_PREPARE;
                            idx_next      = '0;
                            prep_acc_next = '0;
                            main_acc_next = '0;
                            sens_acc_next = '0;
                            state_next    = ST_WALK;
                        end
                        default: ;
                    endcase
                end
            end
            ST_WALK: begin
                if (idx_reg < cur_cnt) begin
                    rd_en    = 1'b1;
                    idx_next = idx_reg + 1'b1;
                end else if (tab_reg == TAB_DYNAMIC) begin
                    state_next = ST_FLUSH;
                end else begin
                    tab_next = tab_reg + 1'b1;
                    idx_next = '0;
                end
            end
            ST_FLUSH: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next                 = 1'b1;
                    out_data_next.main_result      = main_acc_reg;
                    out_data_next.sensitive_result = const_sens_reg | sens_acc_reg;
                    out_data_next.status_value     = view;
                    state_next                     = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            status_reg    <= '0;
            out_valid_reg <= 1'b0;
            rd_pend_reg   <= 1'b0;
            vld_reg       <= '0;
        end else begin
            state_reg     <= state_next;
            status_reg    <= status_next;
            out_valid_reg <= out_valid_next;
            rd_pend_reg   <= rd_en;
            if (mem_we) begin
                vld_reg[mem_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        tab_reg      <= tab_next;
        idx_reg      <= idx_next;
        prep_acc_reg <= prep_acc_next;
        main_acc_reg <= main_acc_next;
        sens_acc_reg <= sens_acc_next;
        out_data_reg <= out_data_next;
        rd_tab_reg   <= tab_reg;
        rd_vld_reg   <= vld_reg[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= '{condition: in_d.entry_condition, effect: in_d.entry_effect};
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int t = 0; t < TABLES; t++) begin
                cnt_reg[t] <= '0;
            end
            const_sens_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                REG_PREPARE_COUNT: cnt_reg[TAB_PREPARE] <= pwdata[CNT_BITS-1:0];
                REG_MAIN_COUNT:    cnt_reg[TAB_MAIN]    <= pwdata[CNT_BITS-1:0];
                REG_STATIC_COUNT:  cnt_reg[TAB_STATIC]  <= pwdata[CNT_BITS-1:0];
                REG_DYNAMIC_COUNT: cnt_reg[TAB_DYNAMIC] <= pwdata[CNT_BITS-1:0];
                REG_CONST_SENS:    const_sens_reg       <= pwdata[WORD_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_PREPARE_COUNT: prdata = APB_DW'(cnt_reg[TAB_PREPARE]);
            REG_MAIN_COUNT:    prdata = APB_DW'(cnt_reg[TAB_MAIN]);
            REG_STATIC_COUNT:  prdata = APB_DW'(cnt_reg[TAB_STATIC]);
            REG_DYNAMIC_COUNT: prdata = APB_DW'(cnt_reg[TAB_DYNAMIC]);
            REG_CONST_SENS:    prdata = APB_DW'(const_sens_reg);
            default:           prdata = '0;
        endcase
    end

    a_write_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (state_reg == ST_IDLE))
        else $error("entry write outside idle");

    a_read_only_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_pend_reg |-> (state_reg == ST_WALK || state_reg == ST_FLUSH))
        else $error("pending read outside walk");

    a_result_from_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_EMIT))
        else $error("result without emit");

    a_walk_index_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK) |-> (idx_reg <= CNT_BITS'(MAX_ENTRIES)))
        else $error("walk index beyond table");

endmodule
`default_nettype wire

FILE: dv/tb.sv
`default_nettype none
module tb;
    import rste_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 6;
    localparam int SETTLE_CYCLES  = 300;
    localparam int QUIET_LIMIT    = 4000;
    localparam int RANDOM_PHASES  = 8;
    localparam int ITEMS_PER_PHASE = 220;
    localparam int MAX_REPORTS    = 10;
    localparam int FIRST_UNUSED_CMD = int'(CMD_RECALC) + 1;
    localparam int LAST_CMD_CODE    = (1 << CMD_BITS) - 1;

    class relay_term_scoreboard;
        logic [WORD_BITS-1:0] status_word;
        logic [WORD_BITS-1:0] cond_mem [DEPTH];
        logic [WORD_BITS-1:0] eff_mem [DEPTH];
        logic [CNT_BITS-1:0]  count_reg [TABLES];
        logic [WORD_BITS-1:0] const_sens;
        out_data_t            expected_terms [$];
        int                   mismatches;
        int                   results_checked;

        function new();
            status_word = '0;
            const_sens = '0;
            mismatches = 0;
            results_checked = 0;
            foreach (cond_mem[i]) begin
                cond_mem[i] = '0;
                eff_mem[i] = '0;
            end
            foreach (count_reg[i]) count_reg[i] = '0;
        endfunction

        function void set_register(reg_idx_t r, logic [APB_DW-1:0] v);
            case (r)
                REG_PREPARE_COUNT: count_reg[TAB_PREPARE] = v[CNT_BITS-1:0];
                REG_MAIN_COUNT:    count_reg[TAB_MAIN] = v[CNT_BITS-1:0];
                REG_STATIC_COUNT:  count_reg[TAB_STATIC] = v[CNT_BITS-1:0];
                REG_DYNAMIC_COUNT: count_reg[TAB_DYNAMIC] = v[CNT_BITS-1:0];
                REG_CONST_SENS:    const_sens = v[WORD_BITS-1:0];
                default: ;
            endcase
        endfunction

        function int clipped(tab_t t);
            int n;
            n = int'(count_reg[t]);
            return (n > MAX_ENTRIES) ? MAX_ENTRIES : n;
        endfunction

        function logic [WORD_BITS-1:0] fired_effects(tab_t t, logic [WORD_BITS-1:0] view);
            logic [WORD_BITS-1:0] acc;
            int base;
            int i;
            acc = '0;
            base = int'(t) * MAX_ENTRIES;
            for (i = 0; i < clipped(t); i++)
                if ((cond_mem[base + i] & ~view) == '0) acc |= eff_mem[base + i];
            return acc;
        endfunction

        // returns 1 when the item changes state or produces a result
        function bit note_item(in_data_t d, in_user_t u);
            logic [WORD_BITS-1:0] view;
            out_data_t r;
            int k;
            case (u.command)
                CMD_SET_BIT:   status_word |= (32'd1 << d.bit_index);
                CMD_CLEAR_BIT: status_word &= ~(32'd1 << d.bit_index);
                CMD_MASKED:    status_word = (status_word & d.keep_bits) | d.on_bits;
                CMD_WRITE: begin
                    if (int'(d.entry_index) >= clipped(tab_t'(u.table_select))) return 0;
                    k = int'(u.table_select) * MAX_ENTRIES + int'(d.entry_index);
                    cond_mem[k] = d.entry_condition;
                    eff_mem[k] = d.entry_effect;
                end
                CMD_RECALC: begin
                    view = status_word | fired_effects(TAB_PREPARE, status_word);
                    r.main_result = fired_effects(TAB_MAIN, view);
                    r.sensitive_result = const_sens | fired_effects(TAB_STATIC, view)
                                         | fired_effects(TAB_DYNAMIC, view);
                    r.status_value = view;
                    expected_terms = {expected_terms, r};
                end
                default: return 0;
            endcase
            return 1;
        endfunction

        function void report(string what, logic [WORD_BITS-1:0] want, logic [WORD_BITS-1:0] got);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("mismatch on %s: expected %08h, got %08h", what, want, got);
        endfunction

        function void check_result(out_data_t got);
            out_data_t want;
            if (expected_terms.size() == 0) begin
                report("unexpected result main_result", '0, got.main_result);
                return;
            end
            want = expected_terms.pop_front();
            results_checked++;
            if (got.main_result !== want.main_result)
                report("main_result", want.main_result, got.main_result);
            if (got.sensitive_result !== want.sensitive_result)
                report("sensitive_result", want.sensitive_result, got.sensitive_result);
            if (got.status_value !== want.status_value)
                report("status_value", want.status_value, got.status_value);
        endfunction
    endclass

    logic              aclk;
    logic              aresetn = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    in_data_t          s_tdata = '0;
    in_user_t          s_tuser = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    out_data_t         m_tdata;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    relay_term_scoreboard predictor;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int effective_items = 0;
    int items_sent = 0;
    int config_loads = 0;
    int quiet_cycles = 0;

    relay_scheme_term_evaluator_unit dut (.*);

    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) predictor.check_result(m_tdata);
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable) || !aresetn)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", quiet_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_item(input in_data_t d, input in_user_t u);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= d;
        s_tuser <= u;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        if (predictor.note_item(d, u)) effective_items++;
    endtask

    task automatic send_fields(input logic [CMD_BITS-1:0] cmd, input logic [BIT_BITS-1:0] b,
                               input logic [WORD_BITS-1:0] on, input logic [WORD_BITS-1:0] keep,
                               input tab_t t, input logic [IDX_BITS-1:0] idx,
                               input logic [WORD_BITS-1:0] cond, input logic [WORD_BITS-1:0] eff);
        in_data_t d;
        in_user_t u;
        d.pad = '0;
        d.bit_index = b;
        d.on_bits = on;
        d.keep_bits = keep;
        d.entry_index = idx;
        d.entry_condition = cond;
        d.entry_effect = eff;
        u.command = cmd;
        u.table_select = t;
        send_item(d, u);
    endtask

    // hold off until every recalculate result has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (predictor.expected_terms.size() != 0);
    endtask

    task automatic write_reg(input reg_idx_t r, input logic [APB_DW-1:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {r, 2'b00};
        pwdata <= v;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        predictor.set_register(r, v);
    endtask

    task automatic load_config(input int pc, input int mc, input int sc, input int dc,
                               input logic [WORD_BITS-1:0] cs);
        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        write_reg(REG_PREPARE_COUNT, pc);
        write_reg(REG_MAIN_COUNT, mc);
        write_reg(REG_STATIC_COUNT, sc);
        write_reg(REG_DYNAMIC_COUNT, dc);
        write_reg(REG_CONST_SENS, cs);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        config_loads++;
    endtask

    function automatic int pick_count();
        return ($urandom_range(0, 4) == 0) ? $urandom_range(0, MAX_ENTRIES) : $urandom_range(1, 8);
    endfunction

    // zero, a random word, few bits set, or a subset of the live status so that entries actually fire
    function automatic logic [WORD_BITS-1:0] sparse_word();
        logic [WORD_BITS-1:0] w;
        int n;
        w = '0;
        case ($urandom_range(0, 9))
            0: w = '0;
            1: w = $urandom;
            2, 3, 4: w = predictor.status_word & $urandom;
            default: begin
                n = $urandom_range(1, 3);
                repeat (n) w[$urandom_range(0, WORD_BITS - 1)] = 1'b1;
            end
        endcase
        return w;
    endfunction

    task automatic send_random();
        in_data_t d;
        in_user_t u;
        int pick;
        int cnt;
        d.pad = '0;
        d.bit_index = BIT_BITS'($urandom);
        d.on_bits = $urandom;
        d.keep_bits = $urandom;
        d.entry_index = IDX_BITS'($urandom);
        d.entry_condition = $urandom;
        d.entry_effect = $urandom;
        u.table_select = TAB_BITS'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
            u.command = CMD_SET_BIT;
        end else if (pick < 33) begin
            u.command = CMD_CLEAR_BIT;
        end else if (pick < 43) begin
            u.command = CMD_MASKED;
            d.keep_bits = $urandom | $urandom;
            d.on_bits = sparse_word();
        end else if (pick < 78) begin
            u.command = CMD_WRITE;
            cnt = predictor.clipped(tab_t'(u.table_select));
            if (cnt > 0 && $urandom_range(0, 99) < 85)
                d.entry_index = IDX_BITS'($urandom_range(0, cnt - 1));
            d.entry_condition = sparse_word();
            if ($urandom_range(0, 1) == 1) d.entry_effect = sparse_word();
        end else if (pick < 97) begin
            u.command = CMD_RECALC;
        end else begin
            u.command = CMD_BITS'($urandom_range(FIRST_UNUSED_CMD, LAST_CMD_CODE));
        end
        send_item(d, u);
    endtask

    initial begin
        int p;
        int target;
        predictor = new();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // reset configuration: empty tables, writes dropped, unused codes, status updates
        send_fields(CMD_RECALC, '0, '0, '0, TAB_PREPARE, '0, '0, '0);
        send_fields(CMD_WRITE, '0, '0, '0, TAB_PREPARE, '0, '0, '1);
        send_fields(CMD_BITS'(FIRST_UNUSED_CMD), '1, '1, '1, TAB_DYNAMIC, '1, '1, '1);
        send_fields(CMD_BITS'(FIRST_UNUSED_CMD + 1), '1, '1, '1, TAB_STATIC, '1, '1, '1);
        send_fields(CMD_BITS'(LAST_CMD_CODE), '1, '1, '1, TAB_MAIN, '1, '1, '1);
        send_fields(CMD_SET_BIT, 5'd0, '0, '0, TAB_PREPARE, '0, '0, '0);
        send_fields(CMD_SET_BIT, 5'd31, '0, '0, TAB_PREPARE, '0, '0, '0);
        send_fields(CMD_CLEAR_BIT, 5'd0, '0, '0, TAB_PREPARE, '0, '0, '0);
        send_fields(CMD_MASKED, '0, '1, '0, TAB_PREPARE, '0, '0, '0);
        send_fields(CMD_RECALC, '0, '0, '0, TAB_PREPARE, '0, '0, '0);
        send_fields(CMD_MASKED, '0, '0, '0, TAB_PREPARE, '0, '0, '0);
        send_fields(CMD_RECALC, '0, '0, '0, TAB_PREPARE, '0, '0, '0);

        // dynamic count above the table size, prepare feeding main and static
        load_config(3, 2, 2, 127, 32'h8000_0001);
        send_fields(CMD_WRITE, '0, '0, '0, TAB_PREPARE, 6'd0, 32'h0000_0001, 32'h0000_0100);
        send_fields(CMD_WRITE, '0, '0, '0, TAB_PREPARE, 6'd2, 32'h0, 32'h4000_0000);
        send_fields(CMD_WRITE, '0, '0, '0, TAB_PREPARE, 6'd3, 32'h0, 32'hFFFF_FFFF);
        send_fields(CMD_WRITE, '0, '0, '0, TAB_MAIN, 6'd0, 32'h0000_0100, 32'h0000_A5A5);
        send_fields(CMD_WRITE, '0, '0, '0, TAB_MAIN, 6'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_fields(CMD_WRITE, '0, '0, '0, TAB_STATIC, 6'd1, 32'h4000_0000, 32'h0000_0010);
        send_fields(CMD_WRITE, '0, '0, '0, TAB_DYNAMIC, 6'd63, 32'h0000_0002, 32'h0000_2000);
        send_fields(CMD_RECALC, '0, '0, '0, TAB_PREPARE, '0, '0, '0);
        send_fields(CMD_SET_BIT, 5'd0, '0, '0, TAB_PREPARE, '0, '0, '0);
        send_fields(CMD_SET_BIT, 5'd1, '0, '0, TAB_PREPARE, '0, '0, '0);
        send_fields(CMD_RECALC, '0, '0, '0, TAB_PREPARE, '0, '0, '0);
        send_fields(CMD_MASKED, '0, '1, '0, TAB_PREPARE, '0, '0, '0);
        send_fields(CMD_RECALC, '0, '0, '0, TAB_PREPARE, '0, '0, '0);
        send_fields(CMD_MASKED, '0, '0, '0, TAB_PREPARE, '0, '0, '0);
        send_fields(CMD_RECALC, '0, '0, '0, TAB_PREPARE, '0, '0, '0);

        for (p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: load_config(MAX_ENTRIES, MAX_ENTRIES, MAX_ENTRIES, MAX_ENTRIES, '0);
                1: load_config(0, 0, 0, 0, '1);
                2: load_config(127, 1, MAX_ENTRIES, 100, $urandom);
                default: load_config(pick_count(), pick_count(), pick_count(), pick_count(),
                                     $urandom & $urandom);
            endcase
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
                default: begin send_idle_pct = 35; recv_stall_pct = 35; end
            endcase
            target = items_sent + ITEMS_PER_PHASE;
            while (items_sent < target) begin
                if ($urandom_range(0, 99) < 2) drain();
                send_random();
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (predictor.expected_terms.size() != 0) begin
            $display("%0d expected results never arrived", predictor.expected_terms.size());
            predictor.mismatches += predictor.expected_terms.size();
        end
        $display("coverage: %0d state-changing items, %0d recalculate results checked",
                 effective_items, predictor.results_checked);
        $display("          across %0d register settings and four idle/stall mixes", config_loads);
        if (predictor.mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("%0d mismatches", predictor.mismatches);
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
`default_nettype wire

FILE: filelist.f
design/rste_pkg.sv
design/relay_scheme_term_evaluator_unit.sv
dv/tb.sv
